// File: rtl/delimited_decimal_command_parser_macros.svh
// assertion macros for the delimited decimal command parser
`ifndef DELIMITED_DECIMAL_COMMAND_PARSER_MACROS_SVH
`define DELIMITED_DECIMAL_COMMAND_PARSER_MACROS_SVH

// condition must hold at every clock edge out of reset
`define DCP_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) else $error(msg);

// implication property checked at every clock edge out of reset
`define DCP_ASSERT_PROP(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

// File: rtl/dcp_pkg.sv
// shared types and constants for the delimited decimal command parser
package dcp_pkg;

  localparam int ARG_CAP     = 8;
  localparam int FIELD_CHARS = 9;
  localparam int STORE_DEPTH = ARG_CAP + 2;
  localparam int FN_W        = $clog2(STORE_DEPTH + 1);
  localparam int CC_W        = $clog2(FIELD_CHARS + 1);
  localparam int VAL_W       = 16;
  localparam int CNT_W       = 4;
  localparam int ARG_SLOTS   = 8;
  localparam int ARG_LSB     = 2 * VAL_W + CNT_W;
  localparam int DROP_BIT    = ARG_LSB + ARG_SLOTS * VAL_W;
  localparam int OUT_W       = ((DROP_BIT + 1 + 7) / 8) * 8;

  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] SEP_RESET    = 8'd58;

  // register indexes on the configuration port
  localparam logic REG_SEPARATOR = 1'b0;

  typedef enum logic [2:0] {
    TOK_NEWLINE,
    TOK_SEP,
    TOK_DIGIT,
    TOK_SPACE,
    TOK_PLUS,
    TOK_MINUS,
    TOK_OTHER
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e  kind;
    logic [3:0] digit;
  } token_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// File: rtl/delimited_decimal_command_parser.sv
// top level of the delimited decimal command parser
// Takes one received character per word and splits each newline-ended frame
// into fields at the configurable separator (reset value ':', register 0 at
// byte address 0). Each field converts like atoi: leading whitespace skipped,
// an optional sign, then digits up to the first non-digit, wrapping to 16
// bits; only the first nine characters of a field count. At the newline one
// result word carries uid, command, argument count, eight argument slots
// (zero when absent) and a flag for fields beyond the ten-entry store. The
// front end classifies bytes and feeds a two-entry token queue; the back end
// retires one token per cycle, unless a newline is held, through a single
// multiply-by-ten-and-add step, so the block sustains one byte per clock while
// no newline is held. A newline waits only while the result register is full
// and not being taken. A newline byte passes the token queue, then the result register.
`include "delimited_decimal_command_parser_macros.svh"

module delimited_decimal_command_parser (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // received character stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,   // [7:0] data_byte
  // parsed frame stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [15:0] uid, [31:16] command, [35:32] arg_count, [51:36] arg_0,
  // [67:52] arg_1, [83:68] arg_2, [99:84] arg_3, [115:100] arg_4,
  // [131:116] arg_5, [147:132] arg_6, [163:148] arg_7, [164] fields_dropped,
  // [167:165] zero
  output logic [dcp_pkg::OUT_W-1:0]  m_axis_tdata
);
  import dcp_pkg::*;

  logic [7:0] sep_q;
  logic       push;
  logic       pop;
  logic       q_valid;
  token_t     tok_in;
  token_t     tok_out;
  q_stat_t    q_stat;

  // register file: only the separator
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_SEPARATOR) ? {24'd0, sep_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_q <= SEP_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_SEPARATOR)) begin
      sep_q <= pwdata[7:0];
    end
  end

  // byte classification
  dcp_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .separator_i   (sep_q),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .token_o       (tok_in)
  );

  // decouples classification from conversion
  dcp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .token_i (tok_in),
    .pop_i   (pop),
    .valid_o (q_valid),
    .token_o (tok_out),
    .stat_o  (q_stat)
  );

  // conversion, field store and result register
  dcp_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .token_i       (tok_out),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // a dropped field means the argument slots were all filled
  `DCP_ASSERT_PROP(a_drop_full, (m_axis_tvalid && m_axis_tdata[DROP_BIT] |-> m_axis_tdata[ARG_LSB-1:2*VAL_W] == CNT_W'(ARG_CAP)), "dropped fields without full argument count")

  // argument count never exceeds the slot count
  `DCP_ASSERT_ALWAYS(a_count_range, (!m_axis_tvalid || (m_axis_tdata[ARG_LSB-1:2*VAL_W] <= CNT_W'(ARG_CAP))), "argument count out of range")

  // an accepted byte leaves the queue non-empty on the next cycle
  `DCP_ASSERT_PROP(a_queue_holds, (s_axis_tvalid && s_axis_tready |=> !q_stat.empty), "accepted byte lost in token queue")

  // the back end only pops from a non-empty queue
  `DCP_ASSERT_PROP(a_pop_nonempty, (pop |-> !q_stat.empty), "pop from empty token queue")

endmodule

// File: rtl/dcp_front.sv
// front end: takes received bytes and classifies them into tokens
module dcp_front (
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
  input  logic [7:0]        separator_i,
  input  dcp_pkg::q_stat_t  q_stat_i,
  output logic              push_o,
  output dcp_pkg::token_t   token_o
);
  import dcp_pkg::*;

  assign s_axis_tready = !q_stat_i.full;
  assign push_o        = s_axis_tvalid && !q_stat_i.full;

  always_comb begin
    token_o.digit = s_axis_tdata[3:0];
    // newline wins over the separator, the separator over any character class
    if (s_axis_tdata == NEWLINE_BYTE) begin
      token_o.kind = TOK_NEWLINE;
    end else if (s_axis_tdata == separator_i) begin
      token_o.kind = TOK_SEP;
    end else if (s_axis_tdata inside {[8'h30:8'h39]}) begin
      token_o.kind = TOK_DIGIT;
    end else if (s_axis_tdata inside {8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0D}) begin
      token_o.kind = TOK_SPACE;
    end else if (s_axis_tdata == 8'h2B) begin
      token_o.kind = TOK_PLUS;
    end else if (s_axis_tdata == 8'h2D) begin
      token_o.kind = TOK_MINUS;
    end else begin
      token_o.kind = TOK_OTHER;
    end
  end

endmodule

// File: rtl/dcp_queue.sv
// two-entry token queue between front and back end
module dcp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  dcp_pkg::token_t   token_i,
  input  logic              pop_i,
  output logic              valid_o,
  output dcp_pkg::token_t   token_o,
  output dcp_pkg::q_stat_t  stat_o
);
  import dcp_pkg::*;

  token_t     entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign valid_o      = (count_q != 2'd0);
  assign token_o      = entry_q[rd_ptr_q];
  assign stat_o.full  = (count_q == 2'd2);
  assign stat_o.empty = (count_q == 2'd0);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= token_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// File: rtl/dcp_back.sv
// back end: field conversion, field store and result word register
module dcp_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       q_valid_i,
  input  dcp_pkg::token_t            token_i,
  output logic                       pop_o,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [dcp_pkg::OUT_W-1:0]  m_axis_tdata
);
  import dcp_pkg::*;

  typedef enum logic [1:0] {
    PH_SKIP,
    PH_NUM,
    PH_DONE
  } phase_e;

  phase_e             phase_q;
  logic               neg_q;
  logic [VAL_W-1:0]   acc_q;
  logic [CC_W-1:0]    cc_q;
  logic [FN_W-1:0]    fn_q;
  logic               ovf_q;
  logic [VAL_W-1:0]   store_q [STORE_DEPTH];
  logic               m_valid_q;
  logic [OUT_W-1:0]   m_data_q;

  logic               out_free;
  logic               room;
  logic [VAL_W-1:0]   field_val;
  logic [VAL_W-1:0]   acc_next;
  logic [VAL_W-1:0]   ent [STORE_DEPTH];
  logic [FN_W-1:0]    total;
  logic [FN_W-1:0]    count;
  logic [OUT_W-1:0]   res;

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  assign out_free  = !m_valid_q || m_axis_tready;
  // a newline needs the result register, every other token goes straight in
  assign pop_o     = q_valid_i && ((token_i.kind != TOK_NEWLINE) || out_free);
  assign room      = (fn_q < FN_W'(STORE_DEPTH));
  assign field_val = neg_q ? (VAL_W'(0) - acc_q) : acc_q;
  // times ten as two shifts and an add, wrapping to 16 bits
  assign acc_next  = (acc_q << 3) + (acc_q << 1) + VAL_W'(token_i.digit);

  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      ent[i] = (room && (fn_q == FN_W'(i))) ? field_val : store_q[i];
    end
    total = fn_q + FN_W'(room);
    count = (total > FN_W'(2)) ? (total - FN_W'(2)) : '0;
    if (count > FN_W'(ARG_CAP)) begin
      count = FN_W'(ARG_CAP);
    end
  end

  always_comb begin
    res                                = '0;
    res[VAL_W-1:0]                     = ent[0];
    res[2*VAL_W-1:VAL_W]               = ent[1];
    res[ARG_LSB-1:2*VAL_W]             = CNT_W'(count);
    res[DROP_BIT]                      = ovf_q || !room;
    for (int k = 0; k < ARG_SLOTS; k++) begin
      if (k < ARG_CAP) begin
        res[ARG_LSB + k*VAL_W +: VAL_W] = ent[(k < ARG_CAP) ? (2 + k) : 0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && (token_i.kind == TOK_NEWLINE)) begin
      m_data_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SKIP;
      neg_q     <= 1'b0;
      acc_q     <= '0;
      cc_q      <= '0;
      fn_q      <= '0;
      ovf_q     <= 1'b0;
      m_valid_q <= 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store_q[i] <= '0;
      end
    end else begin
      if (pop_o && (token_i.kind == TOK_NEWLINE)) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (pop_o) begin
        case (token_i.kind)
          TOK_NEWLINE: begin
            fn_q      <= '0;
            ovf_q     <= 1'b0;
            phase_q   <= PH_SKIP;
            neg_q     <= 1'b0;
            acc_q     <= '0;
            cc_q      <= '0;
            for (int i = 0; i < STORE_DEPTH; i++) begin
              store_q[i] <= '0;
            end
          end
          TOK_SEP: begin
            if (room) begin
              for (int i = 0; i < STORE_DEPTH; i++) begin
                if (fn_q == FN_W'(i)) begin
                  store_q[i] <= field_val;
                end
              end
              fn_q <= fn_q + FN_W'(1);
            end else begin
              ovf_q <= 1'b1;
            end
            phase_q <= PH_SKIP;
            neg_q   <= 1'b0;
            acc_q   <= '0;
            cc_q    <= '0;
          end
          default: begin
            // characters past the field limit are ignored
            if (cc_q < CC_W'(FIELD_CHARS)) begin
              cc_q <= cc_q + CC_W'(1);
              if (phase_q != PH_DONE) begin
                case (token_i.kind)
                  TOK_DIGIT: begin
                    acc_q   <= acc_next;
                    phase_q <= PH_NUM;
                  end
                  TOK_SPACE: begin
                    if (phase_q != PH_SKIP) begin
                      phase_q <= PH_DONE;
                    end
                  end
                  TOK_PLUS, TOK_MINUS: begin
                    if (phase_q == PH_SKIP) begin
                      neg_q   <= (token_i.kind == TOK_MINUS);
                      phase_q <= PH_NUM;
                    end else begin
                      phase_q <= PH_DONE;
                    end
                  end
                  default: begin
                    phase_q <= PH_DONE;
                  end
                endcase
              end
            end
          end
        endcase
      end
    end
  end

endmodule
